[sv/lse_pkg.sv]
// Shared types and constants for the LSB steganography extractor.
package lse_pkg;

  localparam logic [15:0] HEADER_BYTES_RESET = 16'd54;
  localparam logic [4:0]  LEN_LAST_BIT       = 5'd31;
  localparam logic [4:0]  BYTE_LAST_BIT      = 5'd7;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_MLEN   = 3'd1,
    PH_MBYTE  = 3'd2,
    PH_ELEN   = 3'd3,
    PH_EBYTE  = 3'd4,
    PH_DLEN   = 3'd5,
    PH_DBYTE  = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_MAGIC_LEN  = 3'd0,
    KIND_MAGIC_BYTE = 3'd1,
    KIND_EXT_LEN    = 3'd2,
    KIND_EXT_BYTE   = 3'd3,
    KIND_DATA_LEN   = 3'd4,
    KIND_DATA_BYTE  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } result_t;

endpackage

[sv/lse_decode.sv]
// Payload decoder: header skip, bit gathering and section sequencing.
module lse_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  input  logic            in_fire,
  input  logic            pixel_bit,
  input  logic            image_start,
  output logic            res_valid,
  output lse_pkg::result_t res
);
  import lse_pkg::*;

  logic [15:0] header_bytes;
  phase_t      phase, phase_next;
  logic [15:0] header_left, header_left_next;
  logic [4:0]  bit_index, bit_index_next;
  logic [31:0] shift_accum, shift_accum_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;

  // Start-of-image view of the state
  phase_t      ph_s;
  logic [15:0] hl_s;
  logic [4:0]  bi_s;
  logic [31:0] acc_s;
  logic [31:0] br_s;
  logic [31:0] acc_sh;
  logic [31:0] br_dec;
  logic        work;

  always_comb begin
    ph_s  = image_start ? PH_HEADER    : phase;
    hl_s  = image_start ? header_bytes : header_left;
    bi_s  = image_start ? 5'd0         : bit_index;
    acc_s = image_start ? 32'd0        : shift_accum;
    br_s  = image_start ? 32'd0        : bytes_remaining;

    phase_next           = ph_s;
    header_left_next     = hl_s;
    bit_index_next       = bi_s;
    shift_accum_next     = acc_s;
    bytes_remaining_next = br_s;
    res_valid            = 1'b0;
    res.kind             = KIND_MAGIC_LEN;
    res.value            = 32'd0;
    res.last             = 1'b0;
    work                 = 1'b1;

    // Header skip: drop the word while the count runs down
    if (ph_s == PH_HEADER) begin
      if (hl_s != 16'd0) begin
        header_left_next = hl_s - 16'd1;
        work             = 1'b0;
      end else begin
        ph_s  = PH_MLEN;
        bi_s  = 5'd0;
        acc_s = 32'd0;
        phase_next = PH_MLEN;
      end
    end

    acc_sh = {acc_s[30:0], pixel_bit};
    br_dec = br_s - 32'd1;

    if (work) begin
      case (ph_s)
        PH_MLEN, PH_ELEN, PH_DLEN: begin
          if (bi_s != LEN_LAST_BIT) begin
            bit_index_next   = bi_s + 5'd1;
            shift_accum_next = acc_sh;
          end else begin
            bit_index_next       = 5'd0;
            shift_accum_next     = 32'd0;
            bytes_remaining_next = acc_sh;
            res_valid            = 1'b1;
            res.value            = acc_sh;
            res.kind = (ph_s == PH_MLEN) ? KIND_MAGIC_LEN :
                       (ph_s == PH_ELEN) ? KIND_EXT_LEN : KIND_DATA_LEN;
            if (acc_sh != 32'd0)
              phase_next = phase_t'(ph_s + 3'd1);
            else if (ph_s == PH_DLEN)
              phase_next = PH_DONE;
            else
              phase_next = phase_t'(ph_s + 3'd2);
          end
        end
        PH_MBYTE, PH_EBYTE, PH_DBYTE: begin
          if (bi_s != BYTE_LAST_BIT) begin
            bit_index_next   = bi_s + 5'd1;
            shift_accum_next = acc_sh;
          end else begin
            bit_index_next       = 5'd0;
            shift_accum_next     = 32'd0;
            bytes_remaining_next = br_dec;
            res_valid            = 1'b1;
            res.value            = {24'd0, acc_sh[7:0]};
            res.last             = (br_dec == 32'd0);
            res.kind = (ph_s == PH_MBYTE) ? KIND_MAGIC_BYTE :
                       (ph_s == PH_EBYTE) ? KIND_EXT_BYTE : KIND_DATA_BYTE;
            if (br_dec == 32'd0)
              phase_next = (ph_s == PH_DBYTE) ? PH_DONE : phase_t'(ph_s + 3'd1);
          end
        end
        default: begin
          // done or header: hold
        end
      endcase
    end

    res_valid = res_valid & in_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes    <= HEADER_BYTES_RESET;
      phase           <= PH_HEADER;
      header_left     <= 16'd0;
      bit_index       <= 5'd0;
      shift_accum     <= 32'd0;
      bytes_remaining <= 32'd0;
    end else begin
      if (cfg_we) header_bytes <= cfg_wdata;
      if (in_fire) begin
        phase           <= phase_next;
        header_left     <= header_left_next;
        bit_index       <= bit_index_next;
        shift_accum     <= shift_accum_next;
        bytes_remaining <= bytes_remaining_next;
      end
    end
  end

endmodule

[sv/lse_out_buf.sv]
// Two-entry output register with skid slot for the result stream.
module lse_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lse_pkg::result_t  push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output lse_pkg::result_t  out_data
);
  import lse_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid & out_ready;
  assign can_push  = ~skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      // advance: skid word first, else the new word
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[sv/lsb_stego_extractor.sv]
// Top level of the LSB steganography extractor.
// Input stream: one image byte per word on s_tdata, s_tuser flags the first
// byte of an image and restarts decoding (header skip reloads from the
// header register). Bit 0 of each byte past the header is gathered MSB first.
// Output stream: one word per completed length (32 image bytes) or payload
// byte (8 image bytes); m_tuser gives the section kind, m_tlast marks the
// final byte of a section. Bytes after the data section give nothing.
// Throughput: one input word per cycle while s_tready is high; the decoder
// state updates in the accepting cycle; each result is registered to m_tdata.
// The output register plus a skid slot keep s_tready high while a result
// waits; s_tready drops only when both slots hold results and the receiver
// stalls, and rises the cycle after the receiver takes a word.
// Reset clears the decoder (decoding starts with the first byte unless a
// start word arrives), empties the output and sets the header count to 54.
// cfg_we/cfg_wdata write the header byte count; write only while idle.
module lsb_stego_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,   // header_bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] pixel_byte
  input  logic        s_tuser,     // [0] image_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,     // [31:0] decoded_value
  output logic [2:0]  m_tuser,     // [2:0] section_kind
  output logic        m_tlast      // section_last
);
  import lse_pkg::*;

  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t out_word;

  assign in_fire = s_tvalid & s_tready;

  lse_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_fire     (in_fire),
    .pixel_bit   (s_tdata[0]),
    .image_start (s_tuser),
    .res_valid   (res_valid),
    .res         (res)
  );

  lse_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_word)
  );

  assign m_tdata = out_word.value;
  assign m_tuser = out_word.kind;
  assign m_tlast = out_word.last;

endmodule

[tb/tb_top.sv]
// Self-checking stream testbench for the LSB steganography extractor.
module tb_top;
  import lse_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 600_000;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef enum logic [1:0] {SEG_RAW, SEG_WORD, SEG_BYTE, SEG_CFG} seg_t;

  // One directed step: raw bytes (val = count), a 32-bit or 8-bit field
  // spread over bit 0 of successive bytes, or a header register write.
  typedef struct packed {
    seg_t        seg;
    logic        st;
    logic [31:0] val;
    logic [6:0]  fill;
    logic        typed;
    result_t     want;
  } row_t;

  localparam result_t NO_WORD = '0;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] pixel_byte
  logic        s_tuser;   // [0] image_start
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] decoded_value
  logic [2:0]  m_tuser;   // [2:0] section_kind
  logic        m_tlast;   // section_last

  lsb_stego_extractor dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Decoder copy
  phase_t      cur_phase = PH_HEADER;
  logic [15:0] hdr_count = HEADER_BYTES_RESET;
  logic [15:0] skip_left = '0;
  logic [4:0]  bit_cnt = '0;
  logic [31:0] shreg = '0;
  logic [31:0] bytes_left = '0;

  result_t     payload_q[$];
  int unsigned fails = 0;
  int unsigned payload_items = 0;
  int unsigned idle_mode = 0;
  bit          start_next = 1'b0;
  bit          hold_req = 1'b0;

  row_t plan [23] = '{
    '{SEG_WORD, 1'b0, 32'h2,        7'h7F, 1'b1, '{KIND_MAGIC_LEN,  32'h2,        1'b0}},
    '{SEG_BYTE, 1'b0, 32'hFF,       7'h00, 1'b1, '{KIND_MAGIC_BYTE, 32'hFF,       1'b0}},
    '{SEG_BYTE, 1'b0, 32'h00,       7'h7F, 1'b1, '{KIND_MAGIC_BYTE, 32'h00,       1'b1}},
    '{SEG_WORD, 1'b0, 32'h0,        7'h55, 1'b1, '{KIND_EXT_LEN,    32'h0,        1'b0}},
    '{SEG_WORD, 1'b0, 32'h1,        7'h2A, 1'b1, '{KIND_DATA_LEN,   32'h1,        1'b0}},
    '{SEG_BYTE, 1'b0, 32'hA5,       7'h00, 1'b1, '{KIND_DATA_BYTE,  32'hA5,       1'b1}},
    '{SEG_RAW,  1'b0, 32'd12,       7'h00, 1'b0, NO_WORD},
    '{SEG_RAW,  1'b1, 32'd54,       7'h00, 1'b0, NO_WORD},
    '{SEG_WORD, 1'b0, 32'hFFFFFFFF, 7'h00, 1'b1, '{KIND_MAGIC_LEN,  32'hFFFFFFFF, 1'b0}},
    '{SEG_RAW,  1'b0, 32'd5,        7'h00, 1'b0, NO_WORD},
    '{SEG_RAW,  1'b1, 32'd54,       7'h00, 1'b0, NO_WORD},
    '{SEG_WORD, 1'b0, 32'h0,        7'h7F, 1'b1, '{KIND_MAGIC_LEN,  32'h0,        1'b0}},
    '{SEG_WORD, 1'b0, 32'h0,        7'h00, 1'b1, '{KIND_EXT_LEN,    32'h0,        1'b0}},
    '{SEG_WORD, 1'b0, 32'h0,        7'h33, 1'b1, '{KIND_DATA_LEN,   32'h0,        1'b0}},
    '{SEG_RAW,  1'b0, 32'd6,        7'h00, 1'b0, NO_WORD},
    '{SEG_CFG,  1'b0, 32'd0,        7'h00, 1'b0, NO_WORD},
    '{SEG_WORD, 1'b1, 32'h80000001, 7'h4C, 1'b1, '{KIND_MAGIC_LEN,  32'h80000001, 1'b0}},
    '{SEG_BYTE, 1'b0, 32'hC3,       7'h19, 1'b0, NO_WORD},
    '{SEG_CFG,  1'b0, 32'd100,      7'h00, 1'b0, NO_WORD},
    '{SEG_RAW,  1'b1, 32'd100,      7'h00, 1'b0, NO_WORD},
    '{SEG_WORD, 1'b0, 32'h1,        7'h66, 1'b1, '{KIND_MAGIC_LEN,  32'h1,        1'b0}},
    '{SEG_BYTE, 1'b0, 32'h7E,       7'h01, 1'b1, '{KIND_MAGIC_BYTE, 32'h7E,       1'b1}},
    '{SEG_CFG,  1'b0, 32'd54,       7'h00, 1'b0, NO_WORD}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("tb: failure");
    $finish;
  end

  // Advance the decoder copy by one accepted byte; returns 1 when a word is due.
  function automatic bit extract_step(input logic [7:0] pix, input logic st,
                                      output result_t r);
    r = NO_WORD;
    if (st) begin
      cur_phase = PH_HEADER;
      skip_left = hdr_count;
      bit_cnt = '0;
      shreg = '0;
      bytes_left = '0;
    end
    if (cur_phase == PH_HEADER) begin
      if (skip_left != 0) begin
        skip_left = skip_left - 16'd1;
        return 1'b0;
      end
      cur_phase = PH_MLEN;
      bit_cnt = '0;
      shreg = '0;
    end
    if (cur_phase == PH_DONE) return 1'b0;
    shreg = {shreg[30:0], pix[0]};
    if (cur_phase inside {PH_MLEN, PH_ELEN, PH_DLEN}) begin
      if (bit_cnt < LEN_LAST_BIT) begin
        bit_cnt = bit_cnt + 5'd1;
        return 1'b0;
      end
      r.kind = (cur_phase == PH_MLEN) ? KIND_MAGIC_LEN :
               (cur_phase == PH_ELEN) ? KIND_EXT_LEN : KIND_DATA_LEN;
      r.value = shreg;
      r.last = 1'b0;
      bytes_left = shreg;
      bit_cnt = '0;
      shreg = '0;
      // an empty section skips straight to the next length, or to done
      if (r.value != 0) cur_phase = phase_t'(cur_phase + 3'd1);
      else if (cur_phase == PH_DLEN) cur_phase = PH_DONE;
      else cur_phase = phase_t'(cur_phase + 3'd2);
      return 1'b1;
    end
    if (bit_cnt < BYTE_LAST_BIT) begin
      bit_cnt = bit_cnt + 5'd1;
      return 1'b0;
    end
    r.kind = (cur_phase == PH_MBYTE) ? KIND_MAGIC_BYTE :
             (cur_phase == PH_EBYTE) ? KIND_EXT_BYTE : KIND_DATA_BYTE;
    r.value = {24'h0, shreg[7:0]};
    bytes_left = bytes_left - 32'd1;
    r.last = (bytes_left == 0);
    bit_cnt = '0;
    shreg = '0;
    if (r.last) cur_phase = (cur_phase == PH_DBYTE) ? PH_DONE : phase_t'(cur_phase + 3'd1);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
    fails++;
  endtask

  task automatic push_pixel(input logic [7:0] pix, input bit typed, input result_t want);
    result_t r;
    idle_mode = (payload_items < 200) ? 0 : (payload_items < 400) ? 1 : 2;
    while ($urandom_range(0, 99) < ((idle_mode == 0) ? 16 : (idle_mode == 1) ? 69 : 0)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= start_next;
    do @(posedge clk); while (!s_tready);
    if (extract_step(pix, start_next, r)) begin
      payload_q.push_back(typed ? want : r);
    end
    start_next = 1'b0;
    payload_items++;
  endtask

  // Spread a field over bit 0 of nbits bytes, MSB first.
  task automatic send_bits(input logic [31:0] val, input int nbits, input logic [6:0] fill,
                           input bit typed, input result_t want);
    for (int i = nbits - 1; i >= 0; i--) begin
      push_pixel({fill, val[i]}, typed && (i == 0), want);
    end
  endtask

  task automatic send_raw(input int unsigned count);
    logic [7:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      b = 8'($urandom);
      push_pixel(b, 1'b0, NO_WORD);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (payload_q.size() != 0) @(posedge clk);
  endtask

  // Write the header register once the block has gone quiet.
  task automatic retune(input logic [15:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr_count = v;
  endtask

  task automatic play_frame(input int unsigned fr);
    logic [31:0] lens [3];
    int unsigned cut_at;
    bit wild;
    wild = (fr % 5 == 4);
    cut_at = (fr % 4 == 3) ? $urandom_range(0, 2) : 3;
    lens[0] = wild ? $urandom : $urandom_range(0, 4);
    lens[1] = $urandom_range(0, 3);
    lens[2] = (fr == 0) ? 32'd6 : $urandom_range(0, 8);
    start_next = 1'b1;
    send_raw({16'd0, hdr_count});
    for (int s = 0; s < 3; s++) begin
      if (s == cut_at) begin
        // break off mid-length; the next frame restarts the decoder
        send_bits($urandom, int'($urandom_range(1, 31)), 7'($urandom_range(0, 127)),
                  1'b0, NO_WORD);
        return;
      end
      if (fr == 0 && s == 2) hold_req = 1'b1;
      send_bits(lens[s], 32, 7'($urandom_range(0, 127)), 1'b0, NO_WORD);
      for (int unsigned n = 0; n < lens[s] && !(wild && n == 3); n++)
        send_bits($urandom_range(0, 255), 8, 7'($urandom_range(0, 127)), 1'b0, NO_WORD);
      if (wild) return;
      if ($urandom_range(0, 4) == 0) drain_results();
    end
    send_raw($urandom_range(0, 10));
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >=
                     ((idle_mode == 0) ? 69 : (idle_mode == 1) ? 16 : 0));
      end
    end
  end

  always @(posedge clk) begin
    result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (payload_q.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, 32'h0);
      end else begin
        w = payload_q.pop_front();
        if (m_tuser !== w.kind)
          report_mismatch("section kind", {29'd0, m_tuser}, {29'd0, w.kind});
        if (m_tdata !== w.value) report_mismatch("decoded value", m_tdata, w.value);
        if (m_tlast !== w.last)
          report_mismatch("section last", {31'd0, m_tlast}, {31'd0, w.last});
      end
    end
  end

  initial begin
    int unsigned fr;
    logic [15:0] hb;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      start_next = plan[i].st;
      case (plan[i].seg)
        SEG_WORD: send_bits(plan[i].val, 32, plan[i].fill, plan[i].typed, plan[i].want);
        SEG_BYTE: send_bits(plan[i].val, 8, plan[i].fill, plan[i].typed, plan[i].want);
        SEG_RAW:  send_raw(plan[i].val);
        default:  retune(plan[i].val[15:0]);
      endcase
    end

    fr = 0;
    while (payload_items < 600 || fr == 0) begin
      if (fr % 3 == 0) begin
        case ($urandom_range(0, 5))
          0: hb = 16'd0;
          1: hb = HEADER_BYTES_RESET;
          2: hb = 16'($urandom_range(100, 400));
          default: hb = 16'($urandom_range(1, 12));
        endcase
        retune(hb);
      end
      play_frame(fr);
      fr++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
